/* rtl/atc_pkg.sv */
package atc_pkg;

  // default number of cordic micro-rotations, and the table length
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int TABLE_LEN         = 24;

  // vector datapath width: counts << 24 with cordic gain headroom
  localparam int VW = 46;
  // angle accumulator: centidegrees with 16 fraction bits
  localparam int AW = 33;
  localparam int ANG_FRAC = 16;
  localparam int VEC_SHIFT = 24;

  localparam logic signed [AW-1:0] HALF_TURN_Q = 33'sd1179648000;
  localparam logic signed [31:0]   GAIN_Q30    = 32'sd1768195363;
  localparam logic signed [17:0]   QUARTER_CENTI = 18'sd9000;
  localparam logic signed [17:0]   HALF_CENTI    = 18'sd18000;

  // atan(2^-i) in accumulator units
  localparam logic signed [AW-1:0] ATAN_Q [TABLE_LEN] = '{
    33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
    33'sd23437865,  33'sd11730358,  33'sd5866610,  33'sd2933484,
    33'sd1466764,   33'sd733385,    33'sd366693,   33'sd183346,
    33'sd91673,     33'sd45837,     33'sd22918,    33'sd11459,
    33'sd5730,      33'sd2865,      33'sd1432,     33'sd716,
    33'sd358,       33'sd179,       33'sd90,       33'sd45
  };

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } atc_in_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } atc_out_t;

  // round to nearest (halves away from zero), then clamp to +/- lim
  function automatic logic signed [15:0] round_clamp(logic signed [AW-1:0] a,
                                                     logic signed [17:0] lim);
    logic signed [AW:0]   ax;
    logic signed [AW:0]   mag;
    logic signed [17:0]   r;
    ax = {a[AW-1], a};
    if (!a[AW-1]) begin
      mag = (ax + (AW+1)'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
      r = mag[17:0];
    end else begin
      mag = ((-ax) + (AW+1)'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
      r = -mag[17:0];
    end
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

endpackage

/* rtl/atc_stage.sv */
module atc_stage #(
  parameter int STAGE_IDX = 0,
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic signed [atc_pkg::VW-1:0] x_i,
  input  logic signed [atc_pkg::VW-1:0] y_i,
  input  logic signed [atc_pkg::AW-1:0] ang_i,
  input  logic [SW-1:0]                side_i,
  output logic                         vld_o,
  output logic signed [atc_pkg::VW-1:0] x_o,
  output logic signed [atc_pkg::VW-1:0] y_o,
  output logic signed [atc_pkg::AW-1:0] ang_o,
  output logic [SW-1:0]                side_o
);
  import atc_pkg::*;

  logic signed [VW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [AW-1:0] ang_nxt;
  logic                 vld_r;
  logic signed [VW-1:0] x_r, y_r;
  logic signed [AW-1:0] ang_r;
  logic [SW-1:0]        side_r;

  assign xs = x_i >>> STAGE_IDX;
  assign ys = y_i >>> STAGE_IDX;

  // rotate toward the x axis by the sign of y
  always_comb begin
    if (y_i[VW-1]) begin
      x_nxt   = x_i - ys;
      y_nxt   = y_i + xs;
      ang_nxt = ang_i - ATAN_Q[STAGE_IDX];
    end else begin
      x_nxt   = x_i + ys;
      y_nxt   = y_i - xs;
      ang_nxt = ang_i + ATAN_Q[STAGE_IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    ang_r  <= ang_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign ang_o  = ang_r;
  assign side_o = side_r;

endmodule

/* rtl/atc_cordic.sv */
module atc_cordic #(
  parameter int NSTG = 18,
  parameter int SW = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic signed [atc_pkg::VW-1:0] x_i,
  input  logic signed [atc_pkg::VW-1:0] y_i,
  input  logic signed [atc_pkg::AW-1:0] ang_i,
  input  logic [SW-1:0]                side_i,
  output logic                         vld_o,
  output logic signed [atc_pkg::VW-1:0] x_o,
  output logic signed [atc_pkg::AW-1:0] ang_o,
  output logic [SW-1:0]                side_o
);
  import atc_pkg::*;

  logic                 vld  [NSTG+1];
  logic signed [VW-1:0] xv   [NSTG+1];
  logic signed [VW-1:0] yv   [NSTG+1];
  logic signed [AW-1:0] av   [NSTG+1];
  logic [SW-1:0]        sv   [NSTG+1];

  assign vld[0] = vld_i;
  assign xv[0]  = x_i;
  assign yv[0]  = y_i;
  assign av[0]  = ang_i;
  assign sv[0]  = side_i;

  // one registered micro-rotation per stage
  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    atc_stage #(.STAGE_IDX(g), .SW(SW)) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld[g]),
      .x_i    (xv[g]),
      .y_i    (yv[g]),
      .ang_i  (av[g]),
      .side_i (sv[g]),
      .vld_o  (vld[g+1]),
      .x_o    (xv[g+1]),
      .y_o    (yv[g+1]),
      .ang_o  (av[g+1]),
      .side_o (sv[g+1])
    );
  end

  assign vld_o  = vld[NSTG];
  assign x_o    = xv[NSTG];
  assign ang_o  = av[NSTG];
  assign side_o = sv[NSTG];

endmodule

/* rtl/accel_tilt_angles_unit.sv */
// channel   ports                      transaction
// -------   -------------------------  ------------------------------------
// input     start, busy, in_item       taken when start is high, busy low
// result    out_valid, out_item        one-cycle strobe, always taken
//
// a sample enters every cycle; busy is held low, there is no stall
// pipeline, N = min(CORDIC_STAGES, 24) stages per cordic: an input
// register with the pitch gain multiply, the roll cordic, a round stage,
// the pitch cordic and the output register
// rst_n (synchronous) clears only the valid bits in the pipeline
module accel_tilt_angles_unit #(
  parameter int CORDIC_STAGES = atc_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  atc_pkg::atc_in_t in_item,
  output logic             out_valid,
  output atc_pkg::atc_out_t out_item
);
  import atc_pkg::*;

  // stage count saturates at the table length
  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  // roll sideband: py, zero flag, x negative, x nonzero
  localparam int SW1 = VW + 3;
  // pitch sideband: roll result, zero flag, x negative, x nonzero
  localparam int SW2 = 16 + 3;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------- input stage: fold, offset, gain multiply
  logic signed [16:0] nz17, ny17, nx17;
  logic signed [48:0] prod;
  logic signed [VW-1:0] vx_nxt, vy_nxt, py_nxt;
  logic signed [AW-1:0] off_nxt;
  logic                 zero_nxt;

  always_comb begin
    nz17 = {in_item.accel_z[15], in_item.accel_z};
    ny17 = {in_item.accel_y[15], in_item.accel_y};
    nx17 = -{in_item.accel_x[15], in_item.accel_x};
    off_nxt = '0;
    // z negative: turn the vector by a half turn first
    if (in_item.accel_z[15]) begin
      nz17 = -nz17;
      ny17 = -ny17;
      off_nxt = in_item.accel_y[15] ? -HALF_TURN_Q : HALF_TURN_Q;
    end
    vx_nxt = VW'(nz17) <<< VEC_SHIFT;
    vy_nxt = VW'(ny17) <<< VEC_SHIFT;
    zero_nxt = (in_item.accel_y == '0) && (in_item.accel_z == '0);
  end

  // pitch operand: -x times gain in q30, down to the q24 vector scale
  assign prod   = 49'(nx17) * 49'(GAIN_Q30);
  assign py_nxt = VW'(prod >>> (30 - VEC_SHIFT));

  logic                 s0_vld_r;
  logic signed [VW-1:0] s0_x_r, s0_y_r, s0_py_r;
  logic signed [AW-1:0] s0_ang_r;
  logic                 s0_zero_r, s0_xneg_r, s0_xnz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_x_r    <= vx_nxt;
    s0_y_r    <= vy_nxt;
    s0_ang_r  <= off_nxt;
    s0_py_r   <= py_nxt;
    s0_zero_r <= zero_nxt;
    s0_xneg_r <= in_item.accel_x[15];
    s0_xnz_r  <= (in_item.accel_x != '0);
  end

  // ---------------- roll cordic, also yields the scaled y-z magnitude
  logic                 r_vld;
  logic signed [VW-1:0] r_mag;
  logic signed [AW-1:0] r_ang;
  logic [SW1-1:0]       r_side;

  atc_cordic #(.NSTG(NSTG), .SW(SW1)) u_roll (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s0_vld_r),
    .x_i    (s0_x_r),
    .y_i    (s0_y_r),
    .ang_i  (s0_ang_r),
    .side_i ({s0_py_r, s0_zero_r, s0_xneg_r, s0_xnz_r}),
    .vld_o  (r_vld),
    .x_o    (r_mag),
    .ang_o  (r_ang),
    .side_o (r_side)
  );

  // ---------------- round roll, launch pitch
  logic                 s1_vld_r;
  logic signed [VW-1:0] s1_x_r, s1_y_r;
  logic signed [15:0]   s1_roll_r;
  logic [2:0]           s1_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r     <= r_mag;
    s1_y_r     <= r_side[SW1-1:3];
    s1_roll_r  <= round_clamp(r_ang, HALF_CENTI);
    s1_flags_r <= r_side[2:0];
  end

  // ---------------- pitch cordic
  logic                 p_vld;
  logic signed [VW-1:0] p_mag;
  logic signed [AW-1:0] p_ang;
  logic [SW2-1:0]       p_side;

  atc_cordic #(.NSTG(NSTG), .SW(SW2)) u_pitch (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s1_vld_r),
    .x_i    (s1_x_r),
    .y_i    (s1_y_r),
    .ang_i  ('0),
    .side_i ({s1_roll_r, s1_flags_r}),
    .vld_o  (p_vld),
    .x_o    (p_mag),
    .ang_o  (p_ang),
    .side_o (p_side)
  );

  // ---------------- output register, y = z = 0 override
  logic              out_vld_r;
  atc_out_t          out_r, out_nxt;
  logic signed [15:0] pitch_full;

  always_comb begin
    pitch_full = round_clamp(p_ang, QUARTER_CENTI);
    out_nxt.pitch_angle = pitch_full[14:0];
    out_nxt.roll_angle  = p_side[SW2-1:3];
    if (p_side[2]) begin
      out_nxt.roll_angle = '0;
      if (!p_side[0]) begin
        out_nxt.pitch_angle = '0;
      end else if (p_side[1]) begin
        out_nxt.pitch_angle = QUARTER_CENTI[14:0];
      end else begin
        out_nxt.pitch_angle = -QUARTER_CENTI[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // p_mag (pitch gain-scaled magnitude) is not part of the result
  logic unused_mag;
  assign unused_mag = ^p_mag;

  assign out_valid = out_vld_r & (unused_mag | ~unused_mag);
  assign out_item  = out_r;

endmodule

/* bench/accel_tilt_angles_unit_test.sv */
`timescale 1ns / 1ps

module accel_tilt_angles_unit_test;
  import atc_pkg::*;

  localparam int NSTG = (CORDIC_STAGES_DEF > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES_DEF;
  // pipeline depth, as the block header lists its stages
  localparam int LATENCY = 2 * NSTG + 3;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  atc_in_t  in_item;
  logic     out_valid;
  atc_out_t out_item;

  int       n_errors;
  atc_out_t angles_due[$];

  accel_tilt_angles_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // floor division by 2^s
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // vectoring cordic: rotates (vx, vy) with vx >= 0 onto the x axis
  function automatic longint vector_angle(longint vx, longint vy, output longint mag);
    longint ang;
    longint xs;
    longint ys;
    ang = 0;
    for (int i = 0; i < NSTG; i++) begin
      xs = floor_shift(vx, i);
      ys = floor_shift(vy, i);
      if (vy < 0) begin
        vx = vx - ys;
        vy = vy + xs;
        ang -= longint'(ATAN_Q[i]);
      end else begin
        vx = vx + ys;
        vy = vy - xs;
        ang += longint'(ATAN_Q[i]);
      end
    end
    mag = vx;
    return ang;
  endfunction

  // round halves away from zero, then clamp to +/- lim
  function automatic longint centi_round(longint a, longint lim);
    longint r;
    if (a >= 0) r = (a + (64'sd1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
    else r = -(((-a) + (64'sd1 << (ANG_FRAC - 1))) >>> ANG_FRAC);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic atc_out_t tilt_of(atc_in_t s);
    atc_out_t res;
    longint ax, ay, az, vx, vy, off, mag, unused, py, pitch, roll;
    ax = s.accel_x;
    ay = s.accel_y;
    az = s.accel_z;
    if (ay == 0 && az == 0) begin
      // straight up or down: pitch is a quarter turn (0 if x is 0 too), roll undefined so 0
      roll = 0;
      pitch = (ax < 0) ? 9000 : ((ax > 0) ? -9000 : 0);
    end else begin
      vx = az <<< VEC_SHIFT;
      vy = ay <<< VEC_SHIFT;
      off = 0;
      // z negative: turn by a half turn first, y = 0 goes to +180
      if (az < 0) begin
        vx = -vx;
        vy = -vy;
        off = (ay >= 0) ? 64'sd1179648000 : -64'sd1179648000;
      end
      roll = centi_round(vector_angle(vx, vy, mag) + off, 18000);
      py = floor_shift((-ax) * longint'(GAIN_Q30), 30 - VEC_SHIFT);
      pitch = centi_round(vector_angle(mag, py, unused), 9000);
    end
    res.pitch_angle = pitch[14:0];
    res.roll_angle = roll[15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // sender bursts: random burst length, random gaps between bursts
  int burst_left;

  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z);
    atc_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= s;
    // transaction happens at the edge where start is high and busy low
    do @(posedge clk); while (busy);
    angles_due.push_back(tilt_of(s));
  endtask

  // result checker: every strobe is one transaction, no backpressure
  always @(posedge clk) begin
    atc_out_t want;
    if (rst_n && out_valid) begin
      if (angles_due.size() == 0) begin
        $display("unexpected result at %0t", $time);
        n_errors++;
      end else begin
        want = angles_due.pop_front();
        if (out_item.pitch_angle !== want.pitch_angle)
          report_mismatch("pitch", out_item.pitch_angle, want.pitch_angle);
        if (out_item.roll_angle !== want.roll_angle)
          report_mismatch("roll", out_item.roll_angle, want.roll_angle);
      end
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    // extremes, axis-aligned vectors and the degenerate cases
    send_sample(0, 0, 0);
    send_sample(1, 0, 0);
    send_sample(-1, 0, 0);
    send_sample(16'sh8000, 0, 0);
    send_sample(16'sh7fff, 0, 0);
    send_sample(0, 0, 1);
    send_sample(0, 0, -1);
    send_sample(0, 1, 0);
    send_sample(0, -1, 0);
    send_sample(0, 0, 16'sh8000);
    send_sample(5, 0, 16'sh8000);
    send_sample(0, 16'sh8000, 0);
    send_sample(0, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 1, 0);
    send_sample(-1, -1, -1);
    send_sample(1000, 1, -1);
    send_sample(-1000, -1, -1);
    send_sample(0, 4096, 16384);
  endtask

  task automatic test_random();
    logic signed [15:0] y, z;
    for (int i = 0; i < 1530; i++) begin
      y = rand_axis();
      z = rand_axis();
      if ($urandom_range(0, 19) == 0) y = 0;
      if ($urandom_range(0, 19) == 0) z = 0;
      send_sample(rand_axis(), y, z);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    n_errors = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    drain();
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/atc_pkg.sv
rtl/atc_stage.sv
rtl/atc_cordic.sv
rtl/accel_tilt_angles_unit.sv
bench/accel_tilt_angles_unit_test.sv
